// ===== sv/fplog_pkg.sv =====
// Shared constants, types and codes for the fixed-point logarithm unit.
`timescale 1ns / 1ps

package fplog_pkg;

	// Operand and result word, Q(DATA_W-FRAC_BITS).FRAC_BITS.
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	// Normalized mantissa in [1,2) with FRAC_BITS fraction bits.
	localparam int MANT_W    = FRAC_BITS + 1;
	// Integer part of log2 as it lands in the upper bits of the result.
	localparam int IP_W      = DATA_W - FRAC_BITS;
	// Bit position of the leading one of a positive operand.
	localparam int POS_W     = $clog2(DATA_W - 1);
	// Scale registers and configuration data.
	localparam int SCALE_W   = 16;
	localparam int CFG_W     = 16;
	// Signed log2 times zero-extended scale.
	localparam int PROD_W    = DATA_W + SCALE_W + 1;
	localparam int IDX_W     = 1;

	localparam logic [SCALE_W-1:0] LOG10_SCALE_RST = SCALE_W'(19728);
	localparam logic [SCALE_W-1:0] LN_SCALE_RST    = SCALE_W'(45426);

	// Half an LSB of the scaled result, used for rounding.
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_LOG10_SCALE = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_LN_SCALE    = IDX_W'(1);

	// Operation select; the spare code behaves as log2.
	typedef enum logic [1:0] {
		MODE_LOG2  = 2'd0,
		MODE_LOG10 = 2'd1,
		MODE_LN    = 2'd2,
		MODE_SPARE = 2'd3
	} mode_t;

	// One beat in flight through the squaring stages.
	typedef struct packed {
		logic                   valid;
		logic                   nonpos;
		mode_t                  mode;
		logic [MANT_W-1:0]      mant;
		logic signed [IP_W-1:0] ip;
		logic [FRAC_BITS-1:0]   frac;
	} beat_t;

endpackage

// ===== sv/fplog_norm.sv =====
// Normalization: leading-one search, then shift of the operand into [1,2).
`timescale 1ns / 1ps

module fplog_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              in_valid,
	input  logic signed [fplog_pkg::DATA_W-1:0] x_value,
	input  logic [1:0]                        mode,
	output fplog_pkg::beat_t                  beat
);

	logic                              nonpos_c;
	logic [fplog_pkg::POS_W-1:0]       pos_c;

	logic                              valid_s1;
	logic                              nonpos_s1;
	fplog_pkg::mode_t                  mode_s1;
	logic [fplog_pkg::DATA_W-2:0]      x_s1;
	logic [fplog_pkg::POS_W-1:0]       pos_s1;

	logic [fplog_pkg::POS_W-1:0]       shamt_c;
	logic [fplog_pkg::DATA_W-2:0]      xs_c;
	fplog_pkg::beat_t                  beat_c;
	fplog_pkg::beat_t                  beat_s2;

	// Zero and negative operands skip the log and give the most negative value.
	assign nonpos_c = x_value[fplog_pkg::DATA_W-1] || (x_value == '0);

	// Priority encoder: position of the highest set bit below the sign.
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < fplog_pkg::DATA_W - 1; i++) begin
			if (x_value[i]) begin
				pos_c = fplog_pkg::POS_W'(i);
			end
		end
	end

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			nonpos_s1 <= 1'b0;
			mode_s1   <= fplog_pkg::MODE_LOG2;
			x_s1      <= '0;
			pos_s1    <= '0;
		end else if (advance) begin
			valid_s1  <= in_valid;
			nonpos_s1 <= nonpos_c;
			mode_s1   <= fplog_pkg::mode_t'(mode);
			x_s1      <= x_value[fplog_pkg::DATA_W-2:0];
			pos_s1    <= pos_c;
		end
	end

	// Move the leading one to the top; bits shifted out below are dropped.
	assign shamt_c = fplog_pkg::POS_W'(fplog_pkg::DATA_W - 2) - pos_s1;
	assign xs_c    = x_s1 << shamt_c;

	always_comb begin
		beat_c        = '0;
		beat_c.valid  = valid_s1;
		beat_c.nonpos = nonpos_s1;
		beat_c.mode   = mode_s1;
		beat_c.mant   = xs_c[fplog_pkg::DATA_W-2 -: fplog_pkg::MANT_W];
		beat_c.ip     = fplog_pkg::IP_W'(pos_s1) - fplog_pkg::IP_W'(fplog_pkg::FRAC_BITS);
		beat_c.frac   = '0;
	end

	// Stage 2 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s2 <= '0;
		end else if (advance) begin
			beat_s2 <= beat_c;
		end
	end

	assign beat = beat_s2;

	// A positive operand always leaves with its leading one at the mantissa top.
	assert property (@(posedge clk) disable iff (!arst_n)
		beat_s2.valid && !beat_s2.nonpos |-> beat_s2.mant[fplog_pkg::MANT_W-1])
		else $error("normalized mantissa lost its leading one");

endmodule

// ===== sv/fplog_sqstep.sv =====
// One square-and-compare step: produces one fraction bit of log2.
`timescale 1ns / 1ps

module fplog_sqstep (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  fplog_pkg::beat_t in_beat,
	output fplog_pkg::beat_t out_beat
);

	logic [2*fplog_pkg::MANT_W-1:0] sq_c;
	logic                           bit_c;
	fplog_pkg::beat_t               beat_c;
	fplog_pkg::beat_t               beat_s;

	// Square the mantissa; a result of two or more sets the bit and halves it.
	assign sq_c  = (2*fplog_pkg::MANT_W)'(in_beat.mant) * (2*fplog_pkg::MANT_W)'(in_beat.mant);
	assign bit_c = sq_c[2*fplog_pkg::MANT_W-1];

	always_comb begin
		beat_c      = in_beat;
		beat_c.mant = bit_c ? sq_c[2*fplog_pkg::MANT_W-1 -: fplog_pkg::MANT_W]
		                    : sq_c[2*fplog_pkg::MANT_W-2 -: fplog_pkg::MANT_W];
		beat_c.frac = {in_beat.frac[fplog_pkg::FRAC_BITS-2:0], bit_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s <= '0;
		end else if (advance) begin
			beat_s <= beat_c;
		end
	end

	assign out_beat = beat_s;

	// The mantissa stays in [1,2) after every step.
	assert property (@(posedge clk) disable iff (!arst_n)
		beat_s.valid && !beat_s.nonpos |-> beat_s.mant[fplog_pkg::MANT_W-1])
		else $error("squaring step left the mantissa out of range");

endmodule

// ===== sv/fplog_scale.sv =====
// Scaling for log10 and ln: multiply, round half away, floor shift, saturate.
`timescale 1ns / 1ps

module fplog_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  fplog_pkg::beat_t                    in_beat,
	input  logic [fplog_pkg::SCALE_W-1:0]       log10_scale,
	input  logic [fplog_pkg::SCALE_W-1:0]       ln_scale,
	output logic                                out_valid,
	output logic signed [fplog_pkg::DATA_W-1:0] log_result
);

	logic signed [fplog_pkg::DATA_W-1:0] r_c;
	logic                                scaled_c;
	logic [fplog_pkg::SCALE_W-1:0]       scale_c;
	logic signed [fplog_pkg::PROD_W-1:0] prod_c;

	logic                                valid_s1;
	logic                                scaled_s1;
	logic signed [fplog_pkg::DATA_W-1:0] r_s1;
	logic signed [fplog_pkg::PROD_W-1:0] prod_s1;

	logic signed [fplog_pkg::PROD_W-1:0] rnd_c;
	logic signed [fplog_pkg::PROD_W-1:0] q_c;
	logic                                ovf_c;
	logic signed [fplog_pkg::DATA_W-1:0] sat_c;

	logic                                valid_s2;
	logic signed [fplog_pkg::DATA_W-1:0] result_s2;

	// Assemble log2; a non-positive operand gives the most negative value.
	always_comb begin
		if (in_beat.nonpos) begin
			r_c = {1'b1, {(fplog_pkg::DATA_W-1){1'b0}}};
		end else begin
			r_c = {in_beat.ip, in_beat.frac};
		end
	end

	// Pick the scale register; log2 and the spare code pass through.
	always_comb begin
		scaled_c = 1'b0;
		scale_c  = '0;
		case (in_beat.mode)
			fplog_pkg::MODE_LOG10: begin
				scaled_c = 1'b1;
				scale_c  = log10_scale;
			end
			fplog_pkg::MODE_LN: begin
				scaled_c = 1'b1;
				scale_c  = ln_scale;
			end
			default: begin
				scaled_c = 1'b0;
				scale_c  = '0;
			end
		endcase
	end

	assign prod_c = fplog_pkg::PROD_W'(r_c) * fplog_pkg::PROD_W'(signed'({1'b0, scale_c}));

	// Stage 1: product register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			scaled_s1 <= 1'b0;
			r_s1      <= '0;
			prod_s1   <= '0;
		end else if (advance) begin
			valid_s1  <= in_beat.valid;
			scaled_s1 <= scaled_c;
			r_s1      <= r_c;
			prod_s1   <= prod_c;
		end
	end

	// Round half away from zero, then arithmetic shift (floor).
	assign rnd_c = prod_s1[fplog_pkg::PROD_W-1] ? (prod_s1 - fplog_pkg::ROUND_HALF)
	                                            : (prod_s1 + fplog_pkg::ROUND_HALF);
	assign q_c   = rnd_c >>> fplog_pkg::FRAC_BITS;

	// Saturate when the bits above the result word disagree with its sign.
	assign ovf_c = (q_c[fplog_pkg::PROD_W-1:fplog_pkg::DATA_W-1] != '0) &&
	               (q_c[fplog_pkg::PROD_W-1:fplog_pkg::DATA_W-1] != '1);

	always_comb begin
		if (!ovf_c) begin
			sat_c = q_c[fplog_pkg::DATA_W-1:0];
		end else if (q_c[fplog_pkg::PROD_W-1]) begin
			sat_c = {1'b1, {(fplog_pkg::DATA_W-1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(fplog_pkg::DATA_W-1){1'b1}}};
		end
	end

	// Stage 2: output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			result_s2 <= '0;
		end else if (advance) begin
			valid_s2  <= valid_s1;
			result_s2 <= scaled_s1 ? sat_c : r_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign log_result = result_s2;

	// The scale is unsigned, so a non-negative log2 never gives a negative product.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && scaled_s1 && !r_s1[fplog_pkg::DATA_W-1] |-> !prod_s1[fplog_pkg::PROD_W-1])
		else $error("scaled product has the wrong sign");

endmodule

// ===== sv/fixed_point_logarithm_unit_top.sv =====
// Top level of the fixed-point logarithm unit: handshake, scale registers, pipeline.
`timescale 1ns / 1ps

// Computes log2, log10 or ln of a signed Q16.16 operand and returns a signed
// Q16.16 result. The pipeline takes one beat per clock unless it is held.
// A beat passes normalization (search and shift registers), one squaring
// multiplier stage per fraction bit, and the scale multiply with rounding
// and saturation (product and output registers). The whole pipeline holds
// while a finished result is not taken: in_ready is !out_valid || out_ready.
// Zero and negative operands give log2 word 0x8000_0000 (-2^15), which modes
// log10 and ln then scale. The scale registers are written through cfg_we,
// cfg_index and cfg_wdata and should only change while no beat is in flight.
module fixed_point_logarithm_unit_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [fplog_pkg::DATA_W-1:0] x_value,
	input  logic [1:0]                          mode,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fplog_pkg::DATA_W-1:0] log_result,
	input  logic                                cfg_we,
	input  logic [fplog_pkg::IDX_W-1:0]         cfg_index,
	input  logic [fplog_pkg::CFG_W-1:0]         cfg_wdata
);

	logic                             advance;
	logic [fplog_pkg::SCALE_W-1:0]    log10_scale_q;
	logic [fplog_pkg::SCALE_W-1:0]    ln_scale_q;
	fplog_pkg::beat_t                 sq_beat [fplog_pkg::FRAC_BITS+1];

	// The pipeline moves unless a finished result is waiting and not taken.
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// Scale registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log10_scale_q <= fplog_pkg::LOG10_SCALE_RST;
			ln_scale_q    <= fplog_pkg::LN_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fplog_pkg::REG_LOG10_SCALE: log10_scale_q <= cfg_wdata[fplog_pkg::SCALE_W-1:0];
				fplog_pkg::REG_LN_SCALE:    ln_scale_q    <= cfg_wdata[fplog_pkg::SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fplog_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (in_valid),
		.x_value  (x_value),
		.mode     (mode),
		.beat     (sq_beat[0])
	);

	// One squaring stage per fraction bit, most significant bit first.
	for (genvar g = 0; g < fplog_pkg::FRAC_BITS; g++) begin : g_sq
		fplog_sqstep u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.in_beat  (sq_beat[g]),
			.out_beat (sq_beat[g+1])
		);
	end

	fplog_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.in_beat     (sq_beat[fplog_pkg::FRAC_BITS]),
		.log10_scale (log10_scale_q),
		.ln_scale    (ln_scale_q),
		.out_valid   (out_valid),
		.log_result  (log_result)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the fixed-point logarithm unit top level.
`timescale 1ns / 1ps

module testbench;

	localparam int  CLK_HALF     = 5;
	localparam int  RESET_CYCLES = 8;
	localparam int  DRAIN_CYCLES = 40;
	localparam int  CYCLE_LIMIT  = 300000;
	localparam int  RANDOM_PHASE = 330;
	localparam int  PHASES       = 5;
	localparam longint unsigned MANT_ONE = 64'd1 << fplog_pkg::FRAC_BITS;
	localparam longint unsigned MANT_TWO = 64'd2 << fplog_pkg::FRAC_BITS;
	localparam longint          ROUNDING = 64'sd1 <<< (fplog_pkg::FRAC_BITS - 1);

	// One operand waiting for the driver.
	typedef struct {
		logic signed [fplog_pkg::DATA_W-1:0] x;
		fplog_pkg::mode_t                    md;
	} operand_t;

	// One logarithm still owed by the block.
	typedef struct {
		logic signed [fplog_pkg::DATA_W-1:0] x;
		fplog_pkg::mode_t                    md;
		logic signed [fplog_pkg::DATA_W-1:0] log_val;
	} log_entry_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic signed [fplog_pkg::DATA_W-1:0] x_value = '0;
	fplog_pkg::mode_t                    mode = fplog_pkg::MODE_LOG2;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [fplog_pkg::DATA_W-1:0] log_result;
	logic                                cfg_we = 1'b0;
	logic [fplog_pkg::IDX_W-1:0]         cfg_index = '0;
	logic [fplog_pkg::CFG_W-1:0]         cfg_wdata = '0;

	operand_t   operand_q[$];
	log_entry_t log_expect_q[$];
	logic [fplog_pkg::SCALE_W-1:0] log10_gain = fplog_pkg::LOG10_SCALE_RST;
	logic [fplog_pkg::SCALE_W-1:0] ln_gain    = fplog_pkg::LN_SCALE_RST;
	int errors = 0;
	int cycles = 0;

	fixed_point_logarithm_unit_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_value   (x_value),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.log_result(log_result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Logarithm of one operand: log2 by squaring, then the optional scale multiply.
	function automatic logic signed [fplog_pkg::DATA_W-1:0] fixed_log(
			logic signed [fplog_pkg::DATA_W-1:0] x, fplog_pkg::mode_t md);
		longint unsigned                     mant;
		longint                              ipart;
		logic signed [fplog_pkg::DATA_W-1:0] log2_val;
		longint                              gain;
		longint                              prod;
		longint                              q;
		if (x <= 0) begin
			log2_val = {1'b1, {(fplog_pkg::DATA_W-1){1'b0}}};
		end else begin
			mant  = longint'(x);
			ipart = 0;
			// Bring the mantissa into [1,2); the shift count is the integer part.
			while (mant >= MANT_TWO) begin
				mant  = mant >> 1;
				ipart = ipart + 1;
			end
			while (mant < MANT_ONE) begin
				mant  = mant << 1;
				ipart = ipart - 1;
			end
			log2_val = fplog_pkg::DATA_W'(ipart <<< fplog_pkg::FRAC_BITS);
			// Each truncating square doubles the log; overflow past two sets a bit.
			for (int i = 1; i <= fplog_pkg::FRAC_BITS; i++) begin
				mant = (mant * mant) >> fplog_pkg::FRAC_BITS;
				if (mant >= MANT_TWO) begin
					mant = mant >> 1;
					log2_val[fplog_pkg::FRAC_BITS-i] = 1'b1;
				end
			end
		end
		if (md == fplog_pkg::MODE_LOG10)
			gain = log10_gain;
		else if (md == fplog_pkg::MODE_LN)
			gain = ln_gain;
		else
			return log2_val;
		// Round half away from zero on the sign, floor shift, then saturate.
		prod = longint'(log2_val) * gain;
		if (prod >= 0)
			q = (prod + ROUNDING) >>> fplog_pkg::FRAC_BITS;
		else
			q = (prod - ROUNDING) >>> fplog_pkg::FRAC_BITS;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		else if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return fplog_pkg::DATA_W'(q);
	endfunction

	// Random operand, weighted toward the interesting corners of the log.
	function automatic logic signed [fplog_pkg::DATA_W-1:0] random_operand();
		logic [fplog_pkg::DATA_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $urandom & 32'h7FFF_FFFF;
			2: v = 32'h0001_0000 + $urandom_range(0, 511) - 256;
			3: v = (32'd1 << $urandom_range(0, 30)) + $urandom_range(0, 2) - 1;
			4: v = $urandom_range(1, 65535);
			default: v = $urandom | 32'h8000_0000;
		endcase
		return v;
	endfunction

	task automatic add_operand(logic signed [fplog_pkg::DATA_W-1:0] x,
			fplog_pkg::mode_t md);
		operand_t op;
		op.x  = x;
		op.md = md;
		operand_q.push_back(op);
	endtask

	// Called at a falling edge; returns at a falling edge once nothing is in flight.
	task automatic wait_idle();
		while (operand_q.size() != 0 || in_valid || log_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_scale(logic [fplog_pkg::IDX_W-1:0] idx,
			logic [fplog_pkg::SCALE_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= fplog_pkg::CFG_W'(value);
		if (idx == fplog_pkg::REG_LOG10_SCALE)
			log10_gain = value;
		else
			ln_gain = value;
	endtask

	// Driver: bursts of beats from the operand queue with random gaps between them.
	int burst_left = 4;
	int gap_left   = 0;
	always @(posedge clk or negedge arst_n) begin
		log_entry_t ent;
		operand_t   op;
		if (!arst_n) begin
			in_valid <= 1'b0;
			x_value  <= '0;
			mode     <= fplog_pkg::MODE_LOG2;
		end else begin
			if (in_valid && in_ready) begin
				ent.x       = x_value;
				ent.md      = mode;
				ent.log_val = fixed_log(x_value, mode);
				log_expect_q.push_back(ent);
			end
			if (in_valid && !in_ready) begin
				// Hold the beat until it is taken.
			end else if (gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (operand_q.size() != 0) begin
				op = operand_q.pop_front();
				x_value  <= op.x;
				mode     <= op.md;
				in_valid <= 1'b1;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compares each result beat with the oldest owed logarithm.
	int stall_style = 0;
	int stall_count = 0;
	always @(posedge clk or negedge arst_n) begin
		log_entry_t ent;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (log_expect_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h",
						$time, log_result);
					errors++;
				end else begin
					ent = log_expect_q.pop_front();
					if (log_result !== ent.log_val) begin
						$display("%0t: log_result for x=%h mode=%0d: expected %h, actual %h",
							$time, ent.x, ent.md, ent.log_val, log_result);
						errors++;
					end
				end
			end
			// The stall style changes when stall_count runs out.
			if (stall_count == 0) begin
				stall_style = $urandom_range(0, 3);
				stall_count = $urandom_range(20, 80);
			end
			stall_count = stall_count - 1;
			case (stall_style)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Cycle counter guarding against a hung pipeline.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL fixed_point_logarithm_unit_top");
			$finish;
		end
	end

	// Sequence: reset, directed corners, then random phases under varied scales.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset-scale corners: non-positive, extremes, powers of two, near one, 10, e.
		add_operand(32'sh0000_0000, fplog_pkg::MODE_LOG2);
		add_operand(32'shFFFF_FFFF, fplog_pkg::MODE_LOG10);
		add_operand(32'sh8000_0000, fplog_pkg::MODE_LN);
		add_operand(32'sh7FFF_FFFF, fplog_pkg::MODE_LOG2);
		add_operand(32'sh7FFF_FFFF, fplog_pkg::MODE_LOG10);
		add_operand(32'sh7FFF_FFFF, fplog_pkg::MODE_LN);
		add_operand(32'sh0000_0001, fplog_pkg::MODE_LOG2);
		add_operand(32'sh0000_0001, fplog_pkg::MODE_LOG10);
		add_operand(32'sh0000_0001, fplog_pkg::MODE_LN);
		add_operand(32'sh0001_0000, fplog_pkg::MODE_LOG2);
		add_operand(32'sh0001_0000, fplog_pkg::MODE_LOG10);
		add_operand(32'sh0000_FFFF, fplog_pkg::MODE_LOG2);
		add_operand(32'sh0001_0001, fplog_pkg::MODE_LOG2);
		add_operand(32'sh0002_0000, fplog_pkg::MODE_SPARE);
		add_operand(32'sh4000_0000, fplog_pkg::MODE_LN);
		add_operand(32'sh0000_0003, fplog_pkg::MODE_LOG10);
		add_operand(32'sh0000_0000, fplog_pkg::MODE_LOG10);
		add_operand(32'sh0000_0000, fplog_pkg::MODE_LN);
		add_operand(32'sh0000_0000, fplog_pkg::MODE_SPARE);
		add_operand(32'sh8000_0000, fplog_pkg::MODE_LOG10);
		add_operand(32'sh0001_8000, fplog_pkg::MODE_LN);
		add_operand(32'sh000A_0000, fplog_pkg::MODE_LOG10);
		add_operand(32'sh0002_B7E1, fplog_pkg::MODE_LN);
		add_operand(32'shFFFF_0000, fplog_pkg::MODE_SPARE);
		@(negedge clk);
		wait_idle();

		for (int phase = 1; phase <= PHASES; phase++) begin
			// New scales only while the pipeline is empty.
			case (phase)
				1: begin
					write_scale(fplog_pkg::REG_LOG10_SCALE, 16'h0000);
					write_scale(fplog_pkg::REG_LN_SCALE, 16'hFFFF);
				end
				2: begin
					write_scale(fplog_pkg::REG_LOG10_SCALE, 16'hFFFF);
					write_scale(fplog_pkg::REG_LN_SCALE, 16'h0000);
				end
				5: begin
					write_scale(fplog_pkg::REG_LOG10_SCALE, fplog_pkg::LOG10_SCALE_RST);
					write_scale(fplog_pkg::REG_LN_SCALE, fplog_pkg::LN_SCALE_RST);
				end
				default: begin
					write_scale(fplog_pkg::REG_LOG10_SCALE,
						fplog_pkg::SCALE_W'($urandom_range(0, 65535)));
					write_scale(fplog_pkg::REG_LN_SCALE,
						fplog_pkg::SCALE_W'($urandom_range(0, 65535)));
				end
			endcase
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			for (int n = 0; n < RANDOM_PHASE; n++)
				add_operand(random_operand(), fplog_pkg::mode_t'($urandom_range(0, 3)));
			wait_idle();
		end

		// Let any stray beat surface before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS fixed_point_logarithm_unit_top");
		else
			$display("FAIL fixed_point_logarithm_unit_top");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/fplog_pkg.sv
sv/fplog_norm.sv
sv/fplog_sqstep.sv
sv/fplog_scale.sv
sv/fixed_point_logarithm_unit_top.sv
tb/sv/testbench.sv
